/* rtl/core/mlah_pkg.sv */
// shared constants and types for the mip level area histogram
package mlah_pkg;

  localparam int MLAH_LEVELS  = 16;
  localparam int COORD_W      = 16;
  localparam int NUM_COORDS   = 12;
  localparam int IN_W         = COORD_W * NUM_COORDS;
  localparam int LEVEL_W      = 4;
  localparam int TOTAL_W      = 48;
  localparam int OUT_W        = 56;
  localparam int SCALE_W      = 16;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
  localparam int MUL_W        = 18;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int AREA_W       = 34;
  localparam int ADD_W        = AREA_W - 1;
  localparam logic [AREA_W-1:0] ONE_PIXEL = 34'd512;

  typedef enum logic [1:0] {
    OUT_ACCUM = 2'd0,
    OUT_SMALL = 2'd1,
    OUT_NEG   = 2'd2
  } outcome_t;

  // update request into the total bank
  typedef struct packed {
    logic             en;
    logic [ADD_W-1:0] add;
  } bank_req_t;

endpackage

/* rtl/core/mlah_mul.sv */
// shared signed multiplier with registered product
module mlah_mul
  import mlah_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

/* rtl/core/mlah_bank.sv */
// per-level saturating area totals
module mlah_bank
  import mlah_pkg::*;
#(
  parameter int LEVELS = MLAH_LEVELS,
  localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  bank_req_t          req,
  input  logic [LVL_W-1:0]   level,
  output logic [TOTAL_W-1:0] total
);

  logic [TOTAL_W-1:0] totals [LEVELS];
  logic [TOTAL_W:0]   sum;

  // saturating add on the selected entry
  always_comb begin
    sum   = {1'b0, totals[level]} + {{(TOTAL_W + 1 - ADD_W){1'b0}}, req.add};
    total = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        totals[i] <= '0;
      end
    end else if (req.en) begin
      totals[level] <= total;
    end
  end

endmodule

/* rtl/core/mip_level_area_histogram.sv */
// top level of the mip level area histogram
//
// one triangle per input item; the block takes an item only when idle and
// produces exactly one result item for it. a single registered 18x18 multiplier
// is shared for the four cross-product terms and the two halves of the
// scale*texture product. an item runs through the multiply sequence (ST_S1 to
// ST_D4) and the range check (ST_CHK); one under a pixel leaves after ST_T2,
// and one with zero texture area or a level below zero skips the exponent
// search. that search in ST_LVL stops at the found level or the last one, with
// one 62-bit shift and compare per cycle. ST_ADD does the saturating total
// update and ST_DONE hands the result to the output register. the next item is
// taken once the block is back in idle. the hand-off waits while an earlier
// result is still held on the master side. a new item is taken while the
// previous result still waits there. totals reset to zero with rst at once.
// the texture_area_scale register (cfg_we/cfg_data, reset 256) must only be
// written while the block is idle.
module mip_level_area_histogram
  import mlah_pkg::*;
#(
  parameter int LEVELS = MLAH_LEVELS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [SCALE_W-1:0] cfg_data,
  input  logic               s_tvalid,
  output logic               s_tready,
  // screen_x1, screen_y1, screen_x2, screen_y2, screen_x3, screen_y3,
  // tex_u1, tex_v1, tex_u2, tex_v2, tex_u3, tex_v3 (16 bits each, lowest first)
  input  logic [IN_W-1:0]    s_tdata,
  output logic               m_tvalid,
  input  logic               m_tready,
  // level [3:0], level_total [51:4], zero pad [55:52]
  output logic [OUT_W-1:0]   m_tdata,
  // outcome [1:0]
  output logic [1:0]         m_tuser
);

  localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(LEVELS - 1);
  localparam int DIFF_W = COORD_W + 1;
  localparam int D_W    = 50;
  localparam int DD_W   = 62;
  localparam int HALF_W = 17;

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_S1   = 13'b0000000000010,
    ST_S2   = 13'b0000000000100,
    ST_T1   = 13'b0000000001000,
    ST_T2   = 13'b0000000010000,
    ST_D1   = 13'b0000000100000,
    ST_D2   = 13'b0000001000000,
    ST_D3   = 13'b0000010000000,
    ST_D4   = 13'b0000100000000,
    ST_CHK  = 13'b0001000000000,
    ST_LVL  = 13'b0010000000000,
    ST_ADD  = 13'b0100000000000,
    ST_DONE = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [SCALE_W-1:0] scale;

  // vertex differences
  logic signed [DIFF_W-1:0] sxa, sya, sxb, syb;
  logic signed [DIFF_W-1:0] tua, tva, tub, tvb;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] acc;
  logic signed [PROD_W-1:0] cross_diff;
  logic [AREA_W-1:0]        cross_abs;

  logic [AREA_W-1:0] sval;
  logic [AREA_W-1:0] tval;
  logic [D_W-1:0]    d;
  logic [DD_W-1:0]   dd;
  logic [LVL_W-1:0]  lvl;

  // scaled screen area compared against texture area
  logic [AREA_W+25:0] n4;
  logic [AREA_W+24:0] n2;

  outcome_t           res_outcome;
  logic [LVL_W-1:0]   res_level;
  logic [TOTAL_W-1:0] res_total;

  bank_req_t          bank_req;
  logic [TOTAL_W-1:0] bank_total;
  logic               out_free;
  logic               accept;

  function automatic logic signed [DIFF_W-1:0] coord_diff(input logic [COORD_W-1:0] p,
                                                          input logic [COORD_W-1:0] q);
    coord_diff = $signed({p[COORD_W-1], p}) - $signed({q[COORD_W-1], q});
  endfunction

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign cross_diff = acc - prod;
  assign cross_abs  = cross_diff[PROD_W-1] ? AREA_W'(-cross_diff) : AREA_W'(cross_diff);
  assign n4         = {sval, 26'b0};
  assign n2         = {sval, 25'b0};

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_S1: begin
        mul_a = MUL_W'(sxa);
        mul_b = MUL_W'(syb);
      end
      ST_S2: begin
        mul_a = MUL_W'(sya);
        mul_b = MUL_W'(sxb);
      end
      ST_T1: begin
        mul_a = MUL_W'(tua);
        mul_b = MUL_W'(tvb);
      end
      ST_T2: begin
        mul_a = MUL_W'(tva);
        mul_b = MUL_W'(tub);
      end
      ST_D2: begin
        mul_a = $signed({{(MUL_W - SCALE_W){1'b0}}, scale});
        mul_b = $signed({1'b0, tval[HALF_W-1:0]});
      end
      ST_D3: begin
        mul_a = $signed({{(MUL_W - SCALE_W){1'b0}}, scale});
        mul_b = $signed({1'b0, tval[AREA_W-1:HALF_W]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mlah_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign bank_req.en  = (state == ST_ADD);
  assign bank_req.add = sval[AREA_W-1:1];

  mlah_bank #(
    .LEVELS (LEVELS)
  ) u_bank (
    .clk   (clk),
    .rst   (rst),
    .req   (bank_req),
    .level (lvl),
    .total (bank_total)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_S1;
      ST_S1:   state_next = ST_S2;
      ST_S2:   state_next = ST_T1;
      ST_T1:   state_next = ST_T2;
      ST_T2:   state_next = (sval < ONE_PIXEL) ? ST_DONE : ST_D1;
      ST_D1:   state_next = ST_D2;
      ST_D2:   state_next = ST_D3;
      ST_D3:   state_next = ST_D4;
      ST_D4:   state_next = ST_CHK;
      ST_CHK: begin
        if (d == '0) begin
          state_next = ST_ADD;
        end else if (n4 < {10'b0, d}) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_LVL;
        end
      end
      ST_LVL: begin
        if (lvl == LVL_MAX || {3'b0, n2} < dd) state_next = ST_ADD;
      end
      ST_ADD:  state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg_we) begin
      scale <= cfg_data;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      sxa <= coord_diff(s_tdata[2*COORD_W +: COORD_W], s_tdata[0 +: COORD_W]);
      sya <= coord_diff(s_tdata[3*COORD_W +: COORD_W], s_tdata[1*COORD_W +: COORD_W]);
      sxb <= coord_diff(s_tdata[4*COORD_W +: COORD_W], s_tdata[0 +: COORD_W]);
      syb <= coord_diff(s_tdata[5*COORD_W +: COORD_W], s_tdata[1*COORD_W +: COORD_W]);
      tua <= coord_diff(s_tdata[8*COORD_W +: COORD_W], s_tdata[6*COORD_W +: COORD_W]);
      tva <= coord_diff(s_tdata[9*COORD_W +: COORD_W], s_tdata[7*COORD_W +: COORD_W]);
      tub <= coord_diff(s_tdata[10*COORD_W +: COORD_W], s_tdata[8*COORD_W +: COORD_W]);
      tvb <= coord_diff(s_tdata[11*COORD_W +: COORD_W], s_tdata[9*COORD_W +: COORD_W]);
    end
    case (state)
      ST_S2: acc <= prod;
      ST_T1: sval <= cross_abs;
      ST_T2: begin
        acc <= prod;
        if (sval < ONE_PIXEL) begin
          res_outcome <= OUT_SMALL;
          res_level   <= '0;
          res_total   <= '0;
        end
      end
      ST_D1: tval <= cross_abs;
      ST_D3: d <= {{(D_W - 34){1'b0}}, prod[33:0]};
      ST_D4: d <= d + {prod[32:0], {HALF_W{1'b0}}};
      ST_CHK: begin
        // zero texture area picks the top level
        if (d == '0) begin
          lvl <= LVL_MAX;
        end else if (n4 < {10'b0, d}) begin
          res_outcome <= OUT_NEG;
          res_level   <= '0;
          res_total   <= '0;
        end else begin
          lvl <= '0;
          dd  <= {{(DD_W - D_W - 2){1'b0}}, d, 2'b0};
        end
      end
      ST_LVL: begin
        if (!(lvl == LVL_MAX || {3'b0, n2} < dd)) begin
          lvl <= lvl + 1'b1;
          dd  <= {dd[DD_W-3:0], 2'b0};
        end
      end
      ST_ADD: begin
        res_outcome <= OUT_ACCUM;
        res_level   <= lvl;
        res_total   <= bank_total;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {{(OUT_W - TOTAL_W - LEVEL_W){1'b0}}, res_total, LEVEL_W'(res_level)};
      m_tuser <= res_outcome;
    end
  end

  // skipped triangles report zero level and total
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != OUT_ACCUM) |-> (m_tdata == '0))
    else $error("skipped item carries nonzero level or total");

  // zero texture area goes straight to the top level
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHK && d == '0) |=> (state == ST_ADD && lvl == LVL_MAX))
    else $error("zero texture area did not select the top level");

  // an accepted item starts the multiply sequence
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_S1 && !s_tready))
    else $error("accepted item did not start the sequence");

  // the level search never runs past the last level
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_LVL && lvl == LVL_MAX) |=> (state == ST_ADD))
    else $error("level search ran past the last level");

endmodule
